[hdl/elr_pkg.sv]
// shared constants and types for the midpoint ellipse rasterizer
package elr_pkg;

    localparam int COORD_BITS    = 10;
    localparam int OFFS_BITS     = COORD_BITS + 1;
    localparam int PIX_BITS      = COORD_BITS + 2;
    localparam int SQ_BITS       = 2 * COORD_BITS;
    localparam int MUL_BITS      = 2 * COORD_BITS + 4;
    localparam int DEC_BITS      = 2 * MUL_BITS;
    localparam int IN_DATA_BITS  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((4 * PIX_BITS + 7) / 8) * 8;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y = CFG_IDX_BITS'(1);

    localparam logic [COORD_BITS-1:0] CENTER_X_RESET = COORD_BITS'(320);
    localparam logic [COORD_BITS-1:0] CENTER_Y_RESET = COORD_BITS'(240);

    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    typedef enum logic [1:0] {
        SH_X1 = 2'd0,
        SH_X4 = 2'd1,
        SH_X8 = 2'd2
    } t_shift;

    typedef struct packed {
        logic   sub;
        t_shift shift;
    } t_alu_ctl;

    typedef struct packed {
        logic idle;
        logic active;
        logic region_two;
        logic y_zero;
    } t_walk_status;

endpackage

[hdl/elr_mac.sv]
// shared multiplier with registered product and shift-add/subtract accumulator
module elr_mac (
    input  logic                           i_clk,
    input  logic [elr_pkg::MUL_BITS-1:0]   i_mul_a,
    input  logic [elr_pkg::MUL_BITS-1:0]   i_mul_b,
    input  logic [elr_pkg::DEC_BITS-1:0]   i_base,
    input  logic [elr_pkg::DEC_BITS-1:0]   i_term,
    input  elr_pkg::t_alu_ctl              i_ctl,
    output logic [elr_pkg::DEC_BITS-1:0]   o_prod,
    output logic [elr_pkg::DEC_BITS-1:0]   o_sum
);
    import elr_pkg::*;

    logic [DEC_BITS-1:0] r_prod;
    logic [DEC_BITS-1:0] n_prod;
    logic [DEC_BITS-1:0] w_shifted;

    always_comb begin
        n_prod = DEC_BITS'(i_mul_a) * DEC_BITS'(i_mul_b);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    always_comb begin
        case (i_ctl.shift)
            SH_X4:   w_shifted = {i_term[DEC_BITS-3:0], 2'b00};
            SH_X8:   w_shifted = {i_term[DEC_BITS-4:0], 3'b000};
            default: w_shifted = i_term;
        endcase
        o_sum = i_ctl.sub ? (i_base - w_shifted) : (i_base + w_shifted);
    end

    assign o_prod = r_prod;

endmodule

[hdl/elr_seq.sv]
// walk sequencer: holds the ellipse state and steps the shared unit
module elr_seq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_advance,
    input  logic [elr_pkg::COORD_BITS-1:0]  i_radius_x,
    input  logic [elr_pkg::COORD_BITS-1:0]  i_radius_y,
    output logic [elr_pkg::OFFS_BITS-1:0]   o_offset_x,
    output logic [elr_pkg::OFFS_BITS-1:0]   o_offset_y,
    output elr_pkg::t_walk_status           o_status,
    output logic [elr_pkg::MUL_BITS-1:0]    o_mul_a,
    output logic [elr_pkg::MUL_BITS-1:0]    o_mul_b,
    output logic [elr_pkg::DEC_BITS-1:0]    o_base,
    output logic [elr_pkg::DEC_BITS-1:0]    o_term,
    output elr_pkg::t_alu_ctl               o_ctl,
    input  logic [elr_pkg::DEC_BITS-1:0]    i_prod,
    input  logic [elr_pkg::DEC_BITS-1:0]    i_sum
);
    import elr_pkg::*;

    typedef enum logic [19:0] {
        ST_IDLE = 20'h00001,
        ST_LD0  = 20'h00002,
        ST_LD1  = 20'h00004,
        ST_LD2  = 20'h00008,
        ST_LD3  = 20'h00010,
        ST_SE0  = 20'h00020,
        ST_SE1  = 20'h00040,
        ST_SE2  = 20'h00080,
        ST_R2I0 = 20'h00100,
        ST_R2I1 = 20'h00200,
        ST_R2I2 = 20'h00400,
        ST_R2I3 = 20'h00800,
        ST_R2I4 = 20'h01000,
        ST_R2I5 = 20'h02000,
        ST_A1_0 = 20'h04000,
        ST_A1_1 = 20'h08000,
        ST_A1_2 = 20'h10000,
        ST_A2_0 = 20'h20000,
        ST_A2_1 = 20'h40000,
        ST_A2_2 = 20'h80000
    } t_state;

    t_state                r_state, n_state;
    logic [OFFS_BITS-1:0]  r_x, n_x;
    logic [OFFS_BITS-1:0]  r_y, n_y;
    logic [DEC_BITS-1:0]   r_dec, n_dec;
    logic [DEC_BITS-1:0]   r_tmp, n_tmp;
    logic                  r_r2, n_r2;
    logic                  r_active, n_active;
    logic                  r_flag, n_flag;
    logic [COORD_BITS-1:0] r_rx, n_rx;
    logic [COORD_BITS-1:0] r_ry, n_ry;
    logic [SQ_BITS-1:0]    r_a2, n_a2;
    logic [SQ_BITS-1:0]    r_b2, n_b2;

    logic [OFFS_BITS-1:0]  w_x_inc;
    logic [OFFS_BITS-1:0]  w_y_dec;
    logic [OFFS_BITS-1:0]  w_ym1_abs;
    logic [OFFS_BITS:0]    w_2x1;
    logic                  w_dec_neg;
    logic                  w_dec_zero;

    always_comb begin
        w_x_inc    = r_x + OFFS_BITS'(1);
        w_y_dec    = r_y - OFFS_BITS'(1);
        // |y - 1| so the square stays unsigned
        w_ym1_abs  = (r_y == '0) ? OFFS_BITS'(1) : w_y_dec;
        w_2x1      = {r_x, 1'b1};
        w_dec_neg  = r_dec[DEC_BITS-1];
        w_dec_zero = (r_dec == '0);
    end

    always_comb begin
        n_state  = r_state;
        n_x      = r_x;
        n_y      = r_y;
        n_dec    = r_dec;
        n_tmp    = r_tmp;
        n_r2     = r_r2;
        n_active = r_active;
        n_flag   = r_flag;
        n_rx     = r_rx;
        n_ry     = r_ry;
        n_a2     = r_a2;
        n_b2     = r_b2;
        o_mul_a  = '0;
        o_mul_b  = '0;
        o_base   = r_dec;
        o_term   = '0;
        o_ctl    = '{sub: 1'b0, shift: SH_X1};

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_rx     = i_radius_x;
                    n_ry     = i_radius_y;
                    n_x      = '0;
                    n_y      = OFFS_BITS'(i_radius_y);
                    n_r2     = 1'b0;
                    n_active = 1'b1;
                    n_state  = ST_LD0;
                end else if (i_advance) begin
                    if (!r_r2) begin
                        // y steps too when the decision is not negative
                        n_flag  = !w_dec_neg;
                        n_state = ST_A1_0;
                    end else if (r_y != '0) begin
                        // x steps too when the decision is not positive
                        n_flag  = w_dec_neg || w_dec_zero;
                        n_state = ST_A2_0;
                    end else begin
                        n_active = 1'b0;
                    end
                end
            end
            ST_LD0: begin
                o_mul_a = MUL_BITS'(r_rx);
                o_mul_b = MUL_BITS'(r_rx);
                n_state = ST_LD1;
            end
            ST_LD1: begin
                n_a2    = i_prod[SQ_BITS-1:0];
                o_mul_a = MUL_BITS'(r_ry);
                o_mul_b = MUL_BITS'(r_ry);
                n_state = ST_LD2;
            end
            ST_LD2: begin
                n_b2    = i_prod[SQ_BITS-1:0];
                o_mul_a = MUL_BITS'(r_a2);
                o_mul_b = MUL_BITS'(r_ry);
                // a2 + 4*b2
                o_base  = DEC_BITS'(r_a2);
                o_term  = i_prod;
                o_ctl   = '{sub: 1'b0, shift: SH_X4};
                n_dec   = i_sum;
                n_state = ST_LD3;
            end
            ST_LD3: begin
                o_term  = i_prod;
                o_ctl   = '{sub: 1'b1, shift: SH_X4};
                n_dec   = i_sum;
                n_state = ST_SE0;
            end
            ST_SE0: begin
                o_mul_a = MUL_BITS'(r_b2);
                o_mul_b = MUL_BITS'(r_x);
                n_state = ST_SE1;
            end
            ST_SE1: begin
                n_tmp   = i_prod;
                o_mul_a = MUL_BITS'(r_a2);
                o_mul_b = MUL_BITS'(r_y);
                n_state = ST_SE2;
            end
            ST_SE2: begin
                // b2*x - a2*y >= 0 ends region one
                o_base = r_tmp;
                o_term = i_prod;
                o_ctl  = '{sub: 1'b1, shift: SH_X1};
                if (!i_sum[DEC_BITS-1]) begin
                    n_state = ST_R2I0;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_R2I0: begin
                o_mul_a = MUL_BITS'(w_2x1);
                o_mul_b = MUL_BITS'(w_2x1);
                n_state = ST_R2I1;
            end
            ST_R2I1: begin
                o_mul_a = MUL_BITS'(r_b2);
                o_mul_b = i_prod[MUL_BITS-1:0];
                n_state = ST_R2I2;
            end
            ST_R2I2: begin
                n_dec   = i_prod;
                o_mul_a = MUL_BITS'(w_ym1_abs);
                o_mul_b = MUL_BITS'(w_ym1_abs);
                n_state = ST_R2I3;
            end
            ST_R2I3: begin
                o_mul_a = MUL_BITS'(r_a2);
                o_mul_b = i_prod[MUL_BITS-1:0];
                n_state = ST_R2I4;
            end
            ST_R2I4: begin
                o_term  = i_prod;
                o_ctl   = '{sub: 1'b0, shift: SH_X4};
                n_dec   = i_sum;
                o_mul_a = MUL_BITS'(r_a2);
                o_mul_b = MUL_BITS'(r_b2);
                n_state = ST_R2I5;
            end
            ST_R2I5: begin
                o_term  = i_prod;
                o_ctl   = '{sub: 1'b1, shift: SH_X4};
                n_dec   = i_sum;
                n_r2    = 1'b1;
                n_state = ST_IDLE;
            end
            ST_A1_0: begin
                n_x = w_x_inc;
                if (r_flag) begin
                    n_y = w_y_dec;
                end
                o_mul_a = MUL_BITS'(r_b2);
                o_mul_b = MUL_BITS'(w_x_inc);
                o_term  = DEC_BITS'(r_b2);
                o_ctl   = '{sub: 1'b0, shift: SH_X4};
                n_dec   = i_sum;
                n_state = ST_A1_1;
            end
            ST_A1_1: begin
                o_term  = i_prod;
                o_ctl   = '{sub: 1'b0, shift: SH_X8};
                n_dec   = i_sum;
                o_mul_a = MUL_BITS'(r_a2);
                o_mul_b = MUL_BITS'(r_y);
                n_state = ST_A1_2;
            end
            ST_A1_2: begin
                o_term = i_prod;
                o_ctl  = '{sub: 1'b1, shift: SH_X8};
                if (r_flag) begin
                    n_dec = i_sum;
                end
                n_state = ST_SE0;
            end
            ST_A2_0: begin
                n_y = w_y_dec;
                if (r_flag) begin
                    n_x = w_x_inc;
                end
                o_mul_a = MUL_BITS'(r_a2);
                o_mul_b = MUL_BITS'(w_y_dec);
                o_term  = DEC_BITS'(r_a2);
                o_ctl   = '{sub: 1'b0, shift: SH_X4};
                n_dec   = i_sum;
                n_state = ST_A2_1;
            end
            ST_A2_1: begin
                o_term  = i_prod;
                o_ctl   = '{sub: 1'b1, shift: SH_X8};
                n_dec   = i_sum;
                o_mul_a = MUL_BITS'(r_b2);
                o_mul_b = MUL_BITS'(r_x);
                n_state = ST_A2_2;
            end
            ST_A2_2: begin
                o_term = i_prod;
                o_ctl  = '{sub: 1'b0, shift: SH_X8};
                if (r_flag) begin
                    n_dec = i_sum;
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_r2     <= 1'b0;
            r_active <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_r2     <= n_r2;
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_dec  <= n_dec;
        r_tmp  <= n_tmp;
        r_flag <= n_flag;
        r_rx   <= n_rx;
        r_ry   <= n_ry;
        r_a2   <= n_a2;
        r_b2   <= n_b2;
    end

    assign o_offset_x = r_x;
    assign o_offset_y = r_y;
    assign o_status   = '{idle:       (r_state == ST_IDLE),
                          active:     r_active,
                          region_two: r_r2,
                          y_zero:     (r_y == '0)};

endmodule

[hdl/midpoint_ellipse_rasterizer_core.sv]
// top level of the midpoint ellipse rasterizer: handshakes, center registers, output word
//
// channel | dir | handshake            | payload
// --------+-----+----------------------+-------------------------------------------
// s       | in  | i_s_tvalid/o_s_tready | tuser action, tdata radius_x, radius_y
// m       | out | o_m_tvalid/i_m_tready | tdata four pixel coords, tlast last_point
// cfg     | in  | i_cfg_we             | i_cfg_idx register, i_cfg_data value
//
// start word: the walk may open directly in region two
// advance in region one: the word that crosses into region two also sets up that region
// advance in region two: the final point ends the walk without a step
// every step runs on the single multiplier and adder that the sequencer reuses
// a result waits in the output register; a new word is taken once the sequencer is
// idle and that register is free or being drained; reset gives center 320, 240
module midpoint_ellipse_rasterizer_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // radius_x, radius_y, zero pad
    input  logic [elr_pkg::IN_DATA_BITS-1:0]     i_s_tdata,
    // action
    input  logic                                 i_s_tuser,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // pixel_x_right, pixel_x_left, pixel_y_down, pixel_y_up
    output logic [elr_pkg::OUT_DATA_BITS-1:0]    o_m_tdata,
    output logic                                 o_m_tlast,
    input  logic                                 i_cfg_we,
    input  logic [elr_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [elr_pkg::COORD_BITS-1:0]       i_cfg_data
);
    import elr_pkg::*;

    logic [COORD_BITS-1:0]    r_cx;
    logic [COORD_BITS-1:0]    r_cy;
    logic                     r_out_valid;
    logic [OUT_DATA_BITS-1:0] r_out_data;
    logic                     r_out_last;

    logic                     w_accept;
    logic                     w_start;
    logic                     w_advance;
    logic [PIX_BITS-1:0]      w_x_right;
    logic [PIX_BITS-1:0]      w_x_left;
    logic [PIX_BITS-1:0]      w_y_down;
    logic [PIX_BITS-1:0]      w_y_up;

    logic [OFFS_BITS-1:0]     w_offset_x;
    logic [OFFS_BITS-1:0]     w_offset_y;
    t_walk_status             w_status;
    logic [MUL_BITS-1:0]      w_mul_a;
    logic [MUL_BITS-1:0]      w_mul_b;
    logic [DEC_BITS-1:0]      w_base;
    logic [DEC_BITS-1:0]      w_term;
    t_alu_ctl                 w_ctl;
    logic [DEC_BITS-1:0]      w_prod;
    logic [DEC_BITS-1:0]      w_sum;

    assign o_s_tready = w_status.idle && (!r_out_valid || i_m_tready);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_start    = w_accept && (i_s_tuser == ACT_START);
    // an advance with no walk in progress is swallowed
    assign w_advance  = w_accept && (i_s_tuser == ACT_ADVANCE) && w_status.active;

    always_comb begin
        w_x_right = PIX_BITS'(r_cx) + PIX_BITS'(w_offset_x);
        w_x_left  = PIX_BITS'(r_cx) - PIX_BITS'(w_offset_x);
        w_y_down  = PIX_BITS'(r_cy) + PIX_BITS'(w_offset_y);
        w_y_up    = PIX_BITS'(r_cy) - PIX_BITS'(w_offset_y);
    end

    elr_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_advance  (w_advance),
        .i_radius_x (i_s_tdata[COORD_BITS-1:0]),
        .i_radius_y (i_s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .o_offset_x (w_offset_x),
        .o_offset_y (w_offset_y),
        .o_status   (w_status),
        .o_mul_a    (w_mul_a),
        .o_mul_b    (w_mul_b),
        .o_base     (w_base),
        .o_term     (w_term),
        .o_ctl      (w_ctl),
        .i_prod     (w_prod),
        .i_sum      (w_sum)
    );

    elr_mac u_mac (
        .i_clk   (i_clk),
        .i_mul_a (w_mul_a),
        .i_mul_b (w_mul_b),
        .i_base  (w_base),
        .i_term  (w_term),
        .i_ctl   (w_ctl),
        .o_prod  (w_prod),
        .o_sum   (w_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= CENTER_X_RESET;
            r_cy <= CENTER_Y_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CENTER_X: r_cx <= i_cfg_data;
                CFG_CENTER_Y: r_cy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= OUT_DATA_BITS'({w_y_up, w_y_down, w_x_left, w_x_right});
            r_out_last <= w_status.region_two && w_status.y_zero;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule
